FILE: src/frame_deframer_lowpass_xy_top_macros.svh
// assertion macros shared by the deframer rtl
`ifndef FRAME_DEFRAMER_LOWPASS_XY_TOP_MACROS_SVH
`define FRAME_DEFRAMER_LOWPASS_XY_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define FDLP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define FDLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fdlp_pkg.sv
// shared widths, register indexes and codes for the frame deframer
package fdlp_pkg;

    // payload widths
    localparam int BYTE_W     = 8;
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int FLAG_W     = 8;
    localparam int SCALE_W    = 16;
    localparam int ALPHA_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd4;

    // configuration reset values
    localparam logic [BYTE_W-1:0]  HEADER_RST  = 8'd81;
    localparam logic [BYTE_W-1:0]  TRAILER_RST = 8'd82;
    localparam logic [BYTE_W-1:0]  CENTER_RST  = 8'd40;
    localparam logic [SCALE_W-1:0] SCALE_RST   = 16'd5825;
    localparam logic [ALPHA_W-1:0] ALPHA_RST   = 9'd205;

    // frame position codes
    localparam logic [POS_W-1:0] POS_HUNT      = 3'd0;
    localparam logic [POS_W-1:0] POS_FIRST     = 3'd1;
    localparam logic [POS_W-1:0] POS_LAST_BODY = 3'd3;
    localparam logic [POS_W-1:0] POS_TRAIL     = 3'd4;

    // saturation limits
    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

endpackage

FILE: src/fdlp_if.sv
// valid/ready channel interfaces of the frame deframer

// received byte channel
interface fdlp_byte_if
    import fdlp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// filtered position channel
interface fdlp_pos_if
    import fdlp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [FLAG_W-1:0]         target_flag;

    modport source (output valid, output pos_x, output pos_y, output target_flag,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input target_flag,
                    output ready);
endinterface

// configuration write channel
interface fdlp_cfg_if
    import fdlp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/frame_deframer_lowpass_xy_top.sv
// Frame deframer with x/y low-pass smoothing. A byte that does not complete a
// frame leaves the input ready. A trailer that completes a frame starts four
// passes through one bit-serial shift-add multiplier (scale x, smooth x, scale y,
// smooth y), BW bits wide with BW = max(16, FRAC_BITS + 1), each pass made of a
// load step, the shift-add steps and a post step; then the output register loads.
// No byte is taken during that time. A result waits in the output register while
// the next bytes are taken; the output register must be free before the next
// frame's result is loaded. Configuration writes are taken in every cycle.
`include "frame_deframer_lowpass_xy_top_macros.svh"

module frame_deframer_lowpass_xy_top
    import fdlp_pkg::*;
#(
    parameter int FRAC_BITS = 8
)(
    input  logic       clk,
    input  logic       rst_n,
    fdlp_byte_if.sink  rx,
    fdlp_pos_if.source res,
    fdlp_cfg_if.sink   cfg
);

    // multiplier geometry
    localparam int BW    = (FRAC_BITS + 1 > SCALE_W) ? FRAC_BITS + 1 : SCALE_W;
    localparam int AW    = DIFF_W;
    localparam int HW    = AW + 1;
    localparam int PW    = HW + BW;
    localparam int QW    = PW - FRAC_BITS;
    localparam int SW    = QW + 1;
    localparam int CNT_W = $clog2(BW);
    localparam logic [BW-1:0] ONE_B = BW'(1) << FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_MUL  = 5'b00100,
        S_POST = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        PH_SCALE_X  = 2'd0,
        PH_SMOOTH_X = 2'd1,
        PH_SCALE_Y  = 2'd2,
        PH_SMOOTH_Y = 2'd3
    } phase_t;

    // configuration registers
    logic [BYTE_W-1:0]  header_reg;
    logic [BYTE_W-1:0]  trailer_reg;
    logic [BYTE_W-1:0]  center_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    // control state
    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  frame_pos_reg, frame_pos_next;
    logic              out_valid_reg, out_valid_next;

    // datapath state
    logic [BYTE_W-1:0]          body_reg [3];
    logic signed [AW-1:0]       a_reg, a_next;
    logic signed [HW-1:0]       hi_reg, hi_next;
    logic [BW-1:0]              lo_reg, lo_next;
    logic signed [COORD_W-1:0]  raw_reg, raw_next;
    logic signed [COORD_W-1:0]  filt_x_reg, filt_x_next;
    logic signed [COORD_W-1:0]  filt_y_reg, filt_y_next;
    logic signed [COORD_W-1:0]  pos_x_reg, pos_x_next;
    logic signed [COORD_W-1:0]  pos_y_reg, pos_y_next;
    logic [FLAG_W-1:0]          flag_reg, flag_next;

    // combinational terms
    logic                       rx_fire;
    logic                       cfg_fire;
    logic                       is_header;
    logic                       is_trailer;
    logic                       frame_done;
    logic                       body_wr;
    logic [1:0]                 body_idx;
    logic                       out_free;
    logic                       is_y;
    logic                       is_smooth;
    logic [BYTE_W-1:0]          cur_byte;
    logic signed [8:0]          diff;
    logic signed [COORD_W-1:0]  old_val;
    logic signed [AW-1:0]       delta;
    logic [BW-1:0]              alpha_ext;
    logic [BW-1:0]              alpha_eff;
    logic signed [HW-1:0]       addend;
    logic signed [HW-1:0]       sum;
    logic signed [PW-1:0]       prod;
    logic signed [QW-1:0]       q;
    logic                       frac_nz;
    logic signed [QW-1:0]       qt;
    logic                       q_ovf;
    logic signed [COORD_W-1:0]  scaled_sat;
    logic signed [SW-1:0]       s_floor;
    logic signed [SW-1:0]       s_round;
    logic signed [COORD_W-1:0]  smooth_val;

    // handshakes
    assign rx_fire   = rx.valid && rx.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign rx.ready  = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || res.ready;

    // frame byte classification
    assign is_header  = (rx.rx_byte == header_reg);
    assign is_trailer = (rx.rx_byte == trailer_reg);
    assign frame_done = rx_fire && !is_header && is_trailer && (frame_pos_reg == POS_TRAIL);
    assign body_wr    = rx_fire && !is_header && !is_trailer
                        && (frame_pos_reg >= POS_FIRST) && (frame_pos_reg <= POS_LAST_BODY);
    assign body_idx   = 2'(frame_pos_reg - POS_FIRST);

    // operand selection for the current pass
    assign is_y      = (phase_reg == PH_SCALE_Y) || (phase_reg == PH_SMOOTH_Y);
    assign is_smooth = (phase_reg == PH_SMOOTH_X) || (phase_reg == PH_SMOOTH_Y);
    assign cur_byte  = is_y ? body_reg[1] : body_reg[0];
    assign diff      = $signed({1'b0, cur_byte}) - $signed({1'b0, center_reg});
    assign old_val   = is_y ? filt_y_reg : filt_x_reg;
    // old*ONE + a*(raw-old) replaces the two-product blend
    assign delta     = AW'(raw_reg) - AW'(old_val);
    assign alpha_ext = BW'(alpha_reg);
    assign alpha_eff = (alpha_ext > ONE_B) ? ONE_B : alpha_ext;

    // one shift-add step: multiplier bits leave lo, product bits enter from hi
    assign addend = lo_reg[0] ? HW'(a_reg) : '0;
    assign sum    = hi_reg + addend;

    // product split into integer part and fraction
    assign prod    = $signed({hi_reg, lo_reg});
    assign q       = $signed(prod[PW-1:FRAC_BITS]);
    assign frac_nz = |prod[FRAC_BITS-1:0];

    // scaled coordinate, truncated toward zero and saturated
    assign qt         = q + $signed({{(QW-1){1'b0}}, prod[PW-1] & frac_nz});
    assign q_ovf      = !(&qt[QW-1:COORD_W-1]) && (|qt[QW-1:COORD_W-1]);
    assign scaled_sat = q_ovf ? (qt[QW-1] ? COORD_MIN : COORD_MAX) : qt[COORD_W-1:0];

    // smoothed value, truncated toward zero; stays between old and raw
    assign s_floor    = SW'(old_val) + SW'(q);
    assign s_round    = s_floor + $signed({{(SW-1){1'b0}}, s_floor[SW-1] & frac_nz});
    assign smooth_val = s_round[COORD_W-1:0];

    // frame position tracking
    always_comb
    begin
        frame_pos_next = frame_pos_reg;
        if (rx_fire)
        begin
            if (is_header)
                frame_pos_next = POS_FIRST;
            else if (is_trailer)
                frame_pos_next = POS_HUNT;
            else if (body_wr)
                frame_pos_next = frame_pos_reg + POS_FIRST;
            else
                frame_pos_next = POS_HUNT;
        end
    end

    // sequencer and serial datapath
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        a_next         = a_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        raw_next       = raw_reg;
        filt_x_next    = filt_x_reg;
        filt_y_next    = filt_y_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && !res.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (frame_done)
                begin
                    state_next = S_LOAD;
                    phase_next = PH_SCALE_X;
                end
            end
            S_LOAD:
            begin
                a_next     = is_smooth ? delta : AW'(diff);
                lo_next    = is_smooth ? alpha_eff : BW'(scale_reg);
                hi_next    = '0;
                cnt_next   = CNT_W'(BW - 1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                hi_next  = {sum[HW-1], sum[HW-1:1]};
                lo_next  = {sum[0], lo_reg[BW-1:1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = S_POST;
            end
            S_POST:
            begin
                if (!is_smooth)
                    raw_next = scaled_sat;
                else if (is_y)
                    filt_y_next = smooth_val;
                else
                    filt_x_next = smooth_val;
                if (phase_reg == PH_SMOOTH_Y)
                    state_next = S_OUT;
                else
                begin
                    phase_next = phase_t'(phase_reg + 2'd1);
                    state_next = S_LOAD;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pos_x_next     = filt_x_reg;
                    pos_y_next     = filt_y_reg;
                    flag_next      = body_reg[2];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control, filter state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SCALE_X;
            cnt_reg       <= '0;
            frame_pos_reg <= POS_HUNT;
            out_valid_reg <= 1'b0;
            filt_x_reg    <= '0;
            filt_y_reg    <= '0;
            header_reg    <= HEADER_RST;
            trailer_reg   <= TRAILER_RST;
            center_reg    <= CENTER_RST;
            scale_reg     <= SCALE_RST;
            alpha_reg     <= ALPHA_RST;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            frame_pos_reg <= frame_pos_next;
            out_valid_reg <= out_valid_next;
            filt_x_reg    <= filt_x_next;
            filt_y_reg    <= filt_y_next;
            if (cfg_fire)
            begin
                unique case (cfg.index)
                    CFG_HEADER:  header_reg  <= cfg.data[BYTE_W-1:0];
                    CFG_TRAILER: trailer_reg <= cfg.data[BYTE_W-1:0];
                    CFG_CENTER:  center_reg  <= cfg.data[BYTE_W-1:0];
                    CFG_SCALE:   scale_reg   <= cfg.data[SCALE_W-1:0];
                    CFG_ALPHA:   alpha_reg   <= cfg.data[ALPHA_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        raw_reg   <= raw_next;
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        flag_reg  <= flag_next;
        if (body_wr)
            body_reg[body_idx] <= rx.rx_byte;
    end

    // result channel
    assign res.valid       = out_valid_reg;
    assign res.pos_x       = pos_x_reg;
    assign res.pos_y       = pos_y_reg;
    assign res.target_flag = flag_reg;

    // checks
    `FDLP_ASSERT_NEXT(a_frame_start, frame_done, (state_reg == S_LOAD) && (phase_reg == PH_SCALE_X), "completed frame did not start the x scale pass")
    `FDLP_ASSERT_NEXT(a_mul_end, (state_reg == S_MUL) && (cnt_reg == '0), state_reg == S_POST, "multiplier pass did not end after its last step")
    `FDLP_ASSERT_NEXT(a_filt_hold, state_reg != S_POST, $stable(filt_x_reg) && $stable(filt_y_reg), "filter state changed outside a post step")
    `FDLP_ASSERT_NEXT(a_out_load, (state_reg == S_OUT) && out_free, out_valid_reg && (state_reg == S_IDLE), "result not loaded when the output register was free")
    `FDLP_ASSERT_SAME(a_pos_range, 1'b1, frame_pos_reg <= POS_TRAIL, "frame position beyond the trailer slot")

endmodule
